[hdl/rcpwd_pkg.sv]
// Shared types and constants for the RC pulse width decoder.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps

package rcpwd_pkg;

  // defaults for the top level parameters
  localparam int TIME_BITS_DEF  = 32;
  localparam int WIDTH_BITS_DEF = 16;
  localparam int CHANNELS_DEF   = 3;

  // channels with a pin in the input transfer
  localparam int PIN_CHANNELS = 3;

  localparam int REG_BITS      = 16;
  localparam int TIMEOUT_BITS  = 32;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_PULSE   = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_PULSE   = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STALE_TMO   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_IDLE_THR    = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FULL_THR    = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_FB   = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FB_DEADBAND = 3'd6;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_LR   = 3'd7;

  // register reset values
  localparam logic [REG_BITS-1:0]     RST_MIN_PULSE   = 16'd900;
  localparam logic [REG_BITS-1:0]     RST_MAX_PULSE   = 16'd2100;
  localparam logic [TIMEOUT_BITS-1:0] RST_STALE_TMO   = 32'd100000;
  localparam logic [REG_BITS-1:0]     RST_IDLE_THR    = 16'd1100;
  localparam logic [REG_BITS-1:0]     RST_FULL_THR    = 16'd1900;
  localparam logic [REG_BITS-1:0]     RST_CENTER_FB   = 16'd1500;
  localparam logic [REG_BITS-1:0]     RST_FB_DEADBAND = 16'd100;
  localparam logic [REG_BITS-1:0]     RST_CENTER_LR   = 16'd1500;

  // throttle scaling
  localparam int               QUOT_BITS  = 7;
  localparam int               NUMER_BITS = REG_BITS + QUOT_BITS;
  localparam logic [QUOT_BITS-1:0] PCT_FULL = 7'd100;
  localparam logic [QUOT_BITS-1:0] PCT_ZERO = 7'd0;

  // forward/back codes
  localparam logic [1:0] DIR_NEUTRAL  = 2'd0;
  localparam logic [1:0] DIR_FORWARD  = 2'd1;
  localparam logic [1:0] DIR_BACKWARD = 2'd2;

  localparam int OFFSET_BITS = 17;
  localparam int OUT_BITS    = 80;
  localparam int IN_BITS     = 8;

  typedef struct packed {
    logic [REG_BITS-1:0]     min_pulse_us;
    logic [REG_BITS-1:0]     max_pulse_us;
    logic [TIMEOUT_BITS-1:0] stale_timeout_us;
    logic [REG_BITS-1:0]     idle_throttle_us;
    logic [REG_BITS-1:0]     full_throttle_us;
    logic [REG_BITS-1:0]     center_fb_us;
    logic [REG_BITS-1:0]     fb_deadband_us;
    logic [REG_BITS-1:0]     center_lr_us;
  } cfg_t;

  typedef struct packed {
    logic [REG_BITS-1:0]           lr_width_us;
    logic [REG_BITS-1:0]           fb_width_us;
    logic [REG_BITS-1:0]           throttle_width_us;
    logic signed [OFFSET_BITS-1:0] lr_offset_us;
    logic [1:0]                    fb_direction;
    logic [QUOT_BITS-1:0]          throttle_pct;
    logic                          signal_good;
  } result_t;

endpackage

[hdl/rc_pulse_width_decoder.sv]
// RC pulse width decoder, top level: config registers, tick time, lanes,
// output register. Depends on rcpwd_pkg, rcpwd_lane and rcpwd_merge.
`timescale 1ns / 1ps

// Each input transfer is one microsecond tick. The lanes (one per channel) take
// the tick in the cycle it is accepted; the merge stage then gathers results
// and, when the throttle lies strictly between idle and full, passes through a
// launch state, the bit-serial divider, the quotient capture and a finish
// state; a saturated throttle goes straight to the finish state, which waits
// on m_tready while the output register is full. Only one tick is in flight;
// s_tready is low until its result is loaded into the output register.
module rc_pulse_width_decoder #(
  parameter int TIME_BITS  = rcpwd_pkg::TIME_BITS_DEF,
  parameter int WIDTH_BITS = rcpwd_pkg::WIDTH_BITS_DEF,
  parameter int CHANNELS   = rcpwd_pkg::CHANNELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // [0] throttle_level, [1] fb_level, [2] lr_level, [3] hold, [7:4] zero
  input  logic [rcpwd_pkg::IN_BITS-1:0]         s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [0] signal_good, [7:1] throttle_pct, [9:8] fb_direction,
  // [26:10] lr_offset_us, [42:27] throttle_width_us, [58:43] fb_width_us,
  // [74:59] lr_width_us, [79:75] zero
  output logic [rcpwd_pkg::OUT_BITS-1:0]        m_tdata,
  input  logic                                  cfg_we,
  input  logic [rcpwd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [rcpwd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int RB = rcpwd_pkg::REG_BITS;

  rcpwd_pkg::cfg_t    cfg;
  rcpwd_pkg::result_t res;

  logic                  accept;
  logic                  busy;
  logic                  merge_start;
  logic                  load;
  logic                  slot_free;
  logic                  hold;
  logic                  good;
  logic [TIME_BITS-1:0]  time_now;
  logic [TIME_BITS-1:0]  time_next;
  logic [CHANNELS-1:0]   stale;
  logic [CHANNELS-1:0]   level;
  logic [WIDTH_BITS-1:0] lane_width [CHANNELS];
  logic [RB-1:0]         out_width  [rcpwd_pkg::PIN_CHANNELS];

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = !busy;
  assign hold      = s_tdata[3];
  assign time_next = time_now + 1'b1;
  assign slot_free = !m_tvalid || m_tready;
  assign good      = !(|stale);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pulse_us     <= rcpwd_pkg::RST_MIN_PULSE;
      cfg.max_pulse_us     <= rcpwd_pkg::RST_MAX_PULSE;
      cfg.stale_timeout_us <= rcpwd_pkg::RST_STALE_TMO;
      cfg.idle_throttle_us <= rcpwd_pkg::RST_IDLE_THR;
      cfg.full_throttle_us <= rcpwd_pkg::RST_FULL_THR;
      cfg.center_fb_us     <= rcpwd_pkg::RST_CENTER_FB;
      cfg.fb_deadband_us   <= rcpwd_pkg::RST_FB_DEADBAND;
      cfg.center_lr_us     <= rcpwd_pkg::RST_CENTER_LR;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rcpwd_pkg::REG_MIN_PULSE:   cfg.min_pulse_us     <= cfg_wdata[RB-1:0];
        rcpwd_pkg::REG_MAX_PULSE:   cfg.max_pulse_us     <= cfg_wdata[RB-1:0];
        rcpwd_pkg::REG_STALE_TMO:   cfg.stale_timeout_us <= cfg_wdata;
        rcpwd_pkg::REG_IDLE_THR:    cfg.idle_throttle_us <= cfg_wdata[RB-1:0];
        rcpwd_pkg::REG_FULL_THR:    cfg.full_throttle_us <= cfg_wdata[RB-1:0];
        rcpwd_pkg::REG_CENTER_FB:   cfg.center_fb_us     <= cfg_wdata[RB-1:0];
        rcpwd_pkg::REG_FB_DEADBAND: cfg.fb_deadband_us   <= cfg_wdata[RB-1:0];
        rcpwd_pkg::REG_CENTER_LR:   cfg.center_lr_us     <= cfg_wdata[RB-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now    <= '0;
      busy        <= 1'b0;
      merge_start <= 1'b0;
    end else begin
      merge_start <= accept;
      if (accept) begin
        time_now <= time_next;
        busy     <= 1'b1;
      end else if (load) begin
        busy <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    if (k < rcpwd_pkg::PIN_CHANNELS) begin : g_pin
      assign level[k] = s_tdata[k];
    end else begin : g_nopin
      assign level[k] = 1'b0;
    end

    rcpwd_lane #(
      .TIME_BITS  (TIME_BITS),
      .WIDTH_BITS (WIDTH_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .upd       (accept),
      .level     (level[k]),
      .hold      (hold),
      .time_next (time_next),
      .time_now  (time_now),
      .cfg       (cfg),
      .width     (lane_width[k]),
      .stale     (stale[k])
    );
  end

  for (genvar k = 0; k < rcpwd_pkg::PIN_CHANNELS; k++) begin : g_wid
    if (k < CHANNELS) begin : g_have
      assign out_width[k] = RB'(lane_width[k]);
    end else begin : g_none
      assign out_width[k] = '0;
    end
  end

  rcpwd_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (merge_start),
    .good      (good),
    .tw        (out_width[0]),
    .fw        (out_width[1]),
    .lw        (out_width[2]),
    .cfg       (cfg),
    .slot_free (slot_free),
    .load      (load),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= rcpwd_pkg::OUT_BITS'(res);
    end
  end

  a_start_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> merge_start)
    else $error("merge not started after input transfer");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    merge_start |-> !s_tready)
    else $error("input ready while merge pending");

  a_load_slot: assert property (@(posedge clk) disable iff (rst)
    load |-> (busy && (!m_tvalid || m_tready)))
    else $error("result loaded over a pending transfer");

endmodule

[hdl/rcpwd_lane.sv]
// One pulse capture lane: edge detect, width capture and staleness check.
// Depends on rcpwd_pkg.
`timescale 1ns / 1ps

module rcpwd_lane #(
  parameter int TIME_BITS  = rcpwd_pkg::TIME_BITS_DEF,
  parameter int WIDTH_BITS = rcpwd_pkg::WIDTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  upd,
  input  logic                  level,
  input  logic                  hold,
  input  logic [TIME_BITS-1:0]  time_next,
  input  logic [TIME_BITS-1:0]  time_now,
  input  rcpwd_pkg::cfg_t       cfg,
  output logic [WIDTH_BITS-1:0] width,
  output logic                  stale
);

  localparam int CMP_BITS = (TIME_BITS > rcpwd_pkg::TIMEOUT_BITS) ?
                            TIME_BITS : rcpwd_pkg::TIMEOUT_BITS;

  logic                 prev_level;
  logic [TIME_BITS-1:0] rise_stamp;
  logic [TIME_BITS-1:0] last_valid;
  logic [TIME_BITS-1:0] pulse_len;
  logic [TIME_BITS-1:0] gap;
  logic                 in_range;

  assign pulse_len = time_next - rise_stamp;
  assign in_range  = (pulse_len <= TIME_BITS'(cfg.max_pulse_us)) &&
                     (pulse_len >= TIME_BITS'(cfg.min_pulse_us));

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b0;
      rise_stamp <= '0;
      last_valid <= '0;
      width      <= WIDTH_BITS'(rcpwd_pkg::RST_MIN_PULSE);
    end else if (upd) begin
      prev_level <= level;
      if (!hold && (level != prev_level)) begin
        if (level) begin
          rise_stamp <= time_next;
        end else if ((time_next > rise_stamp) && in_range) begin
          width      <= WIDTH_BITS'(pulse_len);
          last_valid <= time_next;
        end
      end
    end
  end

  assign gap   = time_now - last_valid;
  assign stale = CMP_BITS'(gap) > CMP_BITS'(cfg.stale_timeout_us);

endmodule

[hdl/rcpwd_div.sv]
// Restoring divider for the throttle scale, one quotient bit per cycle.
// Depends on rcpwd_pkg. Quotient must fit in QUOT_BITS.
`timescale 1ns / 1ps

module rcpwd_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [rcpwd_pkg::NUMER_BITS-1:0]    numer,
  input  logic [rcpwd_pkg::REG_BITS-1:0]      den,
  output logic                                done,
  output logic [rcpwd_pkg::QUOT_BITS-1:0]     quot
);

  localparam int NB = rcpwd_pkg::NUMER_BITS;
  localparam int QB = rcpwd_pkg::QUOT_BITS;
  localparam int CB = $clog2(QB);

  logic [NB-1:0] rem;
  logic [NB-1:0] dsh;
  logic [CB-1:0] cnt;
  logic          run;
  logic          ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && (cnt == '0)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= numer;
      dsh  <= NB'(den) << (QB - 1);
      cnt  <= CB'(QB - 1);
      quot <= '0;
    end else if (run) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quot <= {quot[QB-2:0], ge};
      dsh  <= dsh >> 1;
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

[hdl/rcpwd_merge.sv]
// Merge stage: combines lane widths and health into one result transfer.
// Depends on rcpwd_pkg and rcpwd_div.
`timescale 1ns / 1ps

module rcpwd_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           good,
  input  logic [rcpwd_pkg::REG_BITS-1:0] tw,
  input  logic [rcpwd_pkg::REG_BITS-1:0] fw,
  input  logic [rcpwd_pkg::REG_BITS-1:0] lw,
  input  rcpwd_pkg::cfg_t                cfg,
  input  logic                           slot_free,
  output logic                           load,
  output rcpwd_pkg::result_t             res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIVGO = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam int RB = rcpwd_pkg::REG_BITS;
  localparam int NB = rcpwd_pkg::NUMER_BITS;

  logic [1:0]                          state;
  logic [1:0]                          state_next;
  logic [RB-1:0]                       diff;
  logic [RB-1:0]                       den;
  logic [NB-1:0]                       numer;
  logic                                div_start;
  logic                                div_done;
  logic [rcpwd_pkg::QUOT_BITS-1:0]     div_quot;
  logic signed [RB+1:0]                fb_off;
  logic signed [RB+1:0]                fb_db;
  logic [1:0]                          dir;
  logic                                sat_full;
  logic                                sat_zero;

  assign sat_full = tw >= cfg.full_throttle_us;
  assign sat_zero = tw <= cfg.idle_throttle_us;
  assign fb_off   = $signed({2'b00, fw}) - $signed({2'b00, cfg.center_fb_us});
  assign fb_db    = $signed({2'b00, cfg.fb_deadband_us});

  always_comb begin
    priority if (fb_off > fb_db) begin
      dir = rcpwd_pkg::DIR_FORWARD;
    end else if (fb_off < -fb_db) begin
      dir = rcpwd_pkg::DIR_BACKWARD;
    end else begin
      dir = rcpwd_pkg::DIR_NEUTRAL;
    end
  end

  assign numer     = NB'(diff) * NB'(rcpwd_pkg::PCT_FULL);
  assign div_start = state == S_DIVGO;
  assign load      = (state == S_FIN) && slot_free;

  rcpwd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (sat_full || sat_zero) ? S_FIN : S_DIVGO;
        end
      end
      S_DIVGO: state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      res.signal_good       <= good;
      res.fb_direction      <= dir;
      res.lr_offset_us      <= rcpwd_pkg::OFFSET_BITS'({1'b0, cfg.center_lr_us} - {1'b0, lw});
      res.throttle_width_us <= tw;
      res.fb_width_us       <= fw;
      res.lr_width_us       <= lw;
      res.throttle_pct      <= sat_full ? rcpwd_pkg::PCT_FULL : rcpwd_pkg::PCT_ZERO;
      diff                  <= tw - cfg.idle_throttle_us;
      den                   <= cfg.full_throttle_us - cfg.idle_throttle_us;
    end else if (div_done) begin
      res.throttle_pct <= div_quot;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("merge started while busy");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide phase");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_quot < rcpwd_pkg::PCT_FULL))
    else $error("throttle quotient out of range");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for rc_pulse_width_decoder: drives microsecond ticks
// over the input stream and checks every output transfer against a tick-level
// predictor. Depends on rcpwd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb;
  import rcpwd_pkg::*;

  localparam int NCH             = CHANNELS_DEF;
  localparam int HOLD_BIT        = 3;
  localparam int NUM_REGS        = 8;
  localparam int RES_BITS        = $bits(result_t);
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int LOW_MAX         = 12;
  localparam int NOISE_PCT       = 8;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_BITS-1:0]       s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_BITS-1:0]      m_tdata;
  logic                     cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  rc_pulse_width_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // decoder state as the predictor sees it
  cfg_t                    cur_cfg;
  logic [31:0]             tick_us;
  logic [NCH-1:0]          pin_was;
  logic [31:0]             rise_us  [NCH];
  logic [REG_BITS-1:0]     width_us [NCH];
  logic [31:0]             valid_us [NCH];

  result_t expected_q[$];
  result_t got_res, want_res;
  int      err_count = 0;
  int      results_seen = 0;
  int      src_idle_pct = 0;
  int      sink_stall_pct = 0;
  int      hold_off_left = 0;
  int      quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic result_t decode_tick(input logic [3:0] pins);
    result_t     r;
    logic [31:0] w;
    logic [REG_BITS-1:0] tw, fw, lw;
    int unsigned num, span;
    int          off, band;
    r = '0;
    tick_us = tick_us + 1'b1;
    for (int c = 0; c < NCH; c++) begin
      if (!pins[HOLD_BIT] && pins[c] != pin_was[c]) begin
        if (pins[c]) begin
          rise_us[c] = tick_us;
        end else if (tick_us > rise_us[c]) begin
          w = tick_us - rise_us[c];
          if (w >= cur_cfg.min_pulse_us && w <= cur_cfg.max_pulse_us) begin
            width_us[c] = w[REG_BITS-1:0];
            valid_us[c] = tick_us;
          end
        end
      end
      pin_was[c] = pins[c];
    end
    r.signal_good = 1'b1;
    for (int c = 0; c < NCH; c++) begin
      w = tick_us - valid_us[c];
      if (w > cur_cfg.stale_timeout_us) r.signal_good = 1'b0;
    end
    tw = width_us[0];
    fw = width_us[1];
    lw = width_us[2];
    if (tw >= cur_cfg.full_throttle_us) begin
      r.throttle_pct = PCT_FULL;
    end else if (tw <= cur_cfg.idle_throttle_us) begin
      r.throttle_pct = PCT_ZERO;
    end else begin
      span = cur_cfg.full_throttle_us - cur_cfg.idle_throttle_us;
      num = tw - cur_cfg.idle_throttle_us;
      num = num * PCT_FULL;
      r.throttle_pct = QUOT_BITS'(num / span);
    end
    off = int'(fw) - int'(cur_cfg.center_fb_us);
    band = int'(cur_cfg.fb_deadband_us);
    if (off > band) r.fb_direction = DIR_FORWARD;
    else if (off < -band) r.fb_direction = DIR_BACKWARD;
    else r.fb_direction = DIR_NEUTRAL;
    r.lr_offset_us = {1'b0, cur_cfg.center_lr_us} - {1'b0, lw};
    r.throttle_width_us = tw;
    r.fb_width_us = fw;
    r.lr_width_us = lw;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR: %s", msg);
    err_count++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d: %s is %0h, expected %0h", results_seen, name, got, want));
  endtask

  // one tick per input transfer; sender may go idle afterwards
  task automatic send_tick(input logic [3:0] pins);
    s_tdata <= IN_BITS'(pins);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(decode_tick(pins));
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  task automatic wait_idle();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_cfg(input cfg_t c);
    logic [CFG_ADDR_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0] val;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = CFG_ADDR_BITS'(i);
      case (idx)
        REG_MIN_PULSE:   val = CFG_DATA_BITS'(c.min_pulse_us);
        REG_MAX_PULSE:   val = CFG_DATA_BITS'(c.max_pulse_us);
        REG_STALE_TMO:   val = CFG_DATA_BITS'(c.stale_timeout_us);
        REG_IDLE_THR:    val = CFG_DATA_BITS'(c.idle_throttle_us);
        REG_FULL_THR:    val = CFG_DATA_BITS'(c.full_throttle_us);
        REG_CENTER_FB:   val = CFG_DATA_BITS'(c.center_fb_us);
        REG_FB_DEADBAND: val = CFG_DATA_BITS'(c.fb_deadband_us);
        REG_CENTER_LR:   val = CFG_DATA_BITS'(c.center_lr_us);
        default:         val = '0;
      endcase
      cfg_we <= 1'b1;
      cfg_addr <= idx;
      cfg_wdata <= val;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  // independent pulse trains per channel, with hold runs and some noise
  task automatic run_pulse_trains(input int n, input int high_max);
    logic [NCH-1:0] lvl;
    int             left [NCH];
    int             hold_left;
    logic [3:0]     pins;
    lvl = '0;
    hold_left = 0;
    for (int c = 0; c < NCH; c++) left[c] = $urandom_range(6, 1);
    repeat (n) begin
      for (int c = 0; c < NCH; c++) begin
        if (left[c] == 0) begin
          lvl[c] = ~lvl[c];
          left[c] = lvl[c] ? $urandom_range(high_max, 1) : $urandom_range(LOW_MAX, 1);
        end
        left[c]--;
      end
      if (hold_left > 0) hold_left--;
      else if ($urandom_range(99) < 3) hold_left = $urandom_range(8, 1);
      pins = {(hold_left > 0), lvl};
      if ($urandom_range(99) < NOISE_PCT) pins = 4'($urandom_range(15));
      send_tick(pins);
    end
  endtask

  task automatic test_reset_state();
    repeat (3) send_tick(4'b0000);
  endtask

  // widths one below min, at min, at max and one above max
  task automatic test_pulse_limits();
    wait_idle();
    load_cfg('{min_pulse_us: 16'd3, max_pulse_us: 16'd6, stale_timeout_us: 32'd8,
               idle_throttle_us: 16'd3, full_throttle_us: 16'd6, center_fb_us: 16'd4,
               fb_deadband_us: 16'd1, center_lr_us: 16'd4});
    repeat (3) send_tick(4'b0111);
    send_tick(4'b0000);
    repeat (2) send_tick(4'b0111);
    repeat (4) send_tick(4'b0110);
    send_tick(4'b0100);
    send_tick(4'b0000);
  endtask

  // edges seen under hold are dropped but the level is still tracked
  task automatic test_hold();
    send_tick(4'b0001);
    send_tick(4'b1000);
    send_tick(4'b0000);
    send_tick(4'b1001);
    repeat (2) send_tick(4'b0001);
    send_tick(4'b0000);
    send_tick(4'b1111);
    send_tick(4'b0111);
    send_tick(4'b0000);
  endtask

  task automatic test_random_traffic();
    wait_idle();
    load_cfg('{min_pulse_us: 16'd3, max_pulse_us: 16'd30, stale_timeout_us: 32'd60,
               idle_throttle_us: 16'd8, full_throttle_us: 16'd24, center_fb_us: 16'd16,
               fb_deadband_us: 16'd4, center_lr_us: 16'd16});
    src_idle_pct = 0;
    sink_stall_pct = 0;
    run_pulse_trains(375, 34);

    // widest limits, zero timeout, largest divisor
    wait_idle();
    load_cfg('{min_pulse_us: 16'd0, max_pulse_us: 16'hFFFF, stale_timeout_us: 32'd0,
               idle_throttle_us: 16'd0, full_throttle_us: 16'hFFFF, center_fb_us: 16'd0,
               fb_deadband_us: 16'd0, center_lr_us: 16'hFFFF});
    src_idle_pct = 70;
    sink_stall_pct = 0;
    run_pulse_trains(375, 40);

    // min above max, full below idle, never stale
    wait_idle();
    load_cfg('{min_pulse_us: 16'd20, max_pulse_us: 16'd5, stale_timeout_us: 32'hFFFF_FFFF,
               idle_throttle_us: 16'd30, full_throttle_us: 16'd10, center_fb_us: 16'hFFFF,
               fb_deadband_us: 16'hFFFF, center_lr_us: 16'd0});
    src_idle_pct = 0;
    sink_stall_pct = 70;
    run_pulse_trains(375, 25);

    // full equal to idle, zero deadband, short timeout
    wait_idle();
    load_cfg('{min_pulse_us: 16'd1, max_pulse_us: 16'd40, stale_timeout_us: 32'd25,
               idle_throttle_us: 16'd12, full_throttle_us: 16'd12, center_fb_us: 16'd10,
               fb_deadband_us: 16'd0, center_lr_us: 16'd30});
    src_idle_pct = 34;
    sink_stall_pct = 34;
    run_pulse_trains(375, 45);

    wait_idle();
    load_cfg('{min_pulse_us: 16'd2, max_pulse_us: 16'd50, stale_timeout_us: 32'd200,
               idle_throttle_us: 16'd5, full_throttle_us: 16'd45, center_fb_us: 16'd20,
               fb_deadband_us: 16'd10, center_lr_us: 16'd20});
    for (int k = 0; k < 4; k++) begin
      src_idle_pct = (k == 1 || k == 3) ? 70 : 0;
      sink_stall_pct = (k >= 2) ? 70 : 0;
      if (k == 3) begin
        src_idle_pct = 34;
        sink_stall_pct = 34;
      end
      run_pulse_trains(94, 55);
    end
  endtask

  // output held off while input keeps offering, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    @(negedge clk);
    hold_off_left = HOLD_OFF_CYCLES;
    @(posedge clk);
    run_pulse_trains(40, 55);
  endtask

  // receiver ready, with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      m_tready <= 1'b0;
      hold_off_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // compare each output transfer with the oldest predicted result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want_res = expected_q.pop_front();
        got_res = result_t'(m_tdata[RES_BITS-1:0]);
        cmp_field("signal_good", got_res.signal_good, want_res.signal_good);
        cmp_field("throttle_pct", got_res.throttle_pct, want_res.throttle_pct);
        cmp_field("fb_direction", got_res.fb_direction, want_res.fb_direction);
        cmp_field("lr_offset_us", got_res.lr_offset_us, want_res.lr_offset_us);
        cmp_field("throttle_width_us", got_res.throttle_width_us,
                  want_res.throttle_width_us);
        cmp_field("fb_width_us", got_res.fb_width_us, want_res.fb_width_us);
        cmp_field("lr_width_us", got_res.lr_width_us, want_res.lr_width_us);
        cmp_field("pad", 32'(m_tdata[OUT_BITS-1:RES_BITS]), '0);
      end
    end
  end

  // watchdog on cycles without any transfer or register write
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cur_cfg = '{min_pulse_us: RST_MIN_PULSE, max_pulse_us: RST_MAX_PULSE,
                stale_timeout_us: RST_STALE_TMO, idle_throttle_us: RST_IDLE_THR,
                full_throttle_us: RST_FULL_THR, center_fb_us: RST_CENTER_FB,
                fb_deadband_us: RST_FB_DEADBAND, center_lr_us: RST_CENTER_LR};
    tick_us = '0;
    pin_was = '0;
    for (int c = 0; c < NCH; c++) begin
      rise_us[c] = '0;
      width_us[c] = RST_MIN_PULSE;
      valid_us[c] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_pulse_limits();
    test_hold();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
